[hw/rtl/spdsf_pkg.sv]
// ----------------------------------------------------------------------------
// spdsf_pkg
// Shared constants and helpers for the SPIR-V debug strip filter.
// ----------------------------------------------------------------------------
package spdsf_pkg;

  localparam int unsigned HeaderWordsDefault = 5;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned FaultW = 2;

  // Debug opcodes
  localparam logic [15:0] OpNop             = 16'd0;
  localparam logic [15:0] OpSourceContinued = 16'd2;
  localparam logic [15:0] OpSource          = 16'd3;
  localparam logic [15:0] OpSourceExtension = 16'd4;
  localparam logic [15:0] OpName            = 16'd5;
  localparam logic [15:0] OpMemberName      = 16'd6;
  localparam logic [15:0] OpString          = 16'd7;
  localparam logic [15:0] OpLine            = 16'd8;
  localparam logic [15:0] OpNoLine          = 16'd317;
  localparam logic [15:0] OpModuleProcessed = 16'd330;

  // Fault codes
  localparam logic [FaultW-1:0] FaultNone      = 2'd0;
  localparam logic [FaultW-1:0] FaultZeroCount = 2'd1;
  localparam logic [FaultW-1:0] FaultTruncated = 2'd2;

  function automatic logic is_debug_op(input logic [15:0] op);
    logic dbg;
    dbg = 1'b0;
    case (op)
      OpNop, OpSourceContinued, OpSource, OpSourceExtension, OpName,
      OpMemberName, OpString, OpLine, OpNoLine, OpModuleProcessed: dbg = 1'b1;
      default: dbg = 1'b0;
    endcase
    return dbg;
  endfunction

endpackage

[hw/rtl/spirv_debug_strip_filter_unit.sv]
// ----------------------------------------------------------------------------
// spirv_debug_strip_filter_unit
// Marks each word of a SPIR-V module as kept or dropped (debug instruction).
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | sink      | in_valid_i / in_ready_o | in_word_i, module_end_i
//  out     | source    | out_valid_o/out_ready_i | out_word_o, keep_o,
//          |           |                         | stream_end_o, fault_o
//
// One word per cycle unless the output stalls; a word passes the input register,
// then the result register, with the header/instruction countdown between them.
// rst_ni clears the valid flags and the parse state to the start of a header.
// A stall on the output backs up through both registers; a new transfer is
// taken whenever the input register empties or moves on in the same cycle.
// ----------------------------------------------------------------------------
module spirv_debug_strip_filter_unit
  import spdsf_pkg::*;
#(
  parameter int unsigned HEADER_WORDS = HeaderWordsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WordW-1:0]  in_word_i,
  input  logic              module_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  out_word_o,
  output logic              keep_o,
  output logic              stream_end_o,
  output logic [FaultW-1:0] fault_o
);

  localparam int unsigned HdrW = $clog2(HEADER_WORDS + 1);
  localparam logic [HdrW-1:0] HdrReset = HdrW'(HEADER_WORDS);

  // input register
  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_end_q;

  // parse state
  logic [HdrW-1:0]   hdr_left_q, hdr_left_d;
  logic [CountW-1:0] words_left_q, words_left_d;
  logic              dropping_q, dropping_d;

  // result register
  logic              out_valid_q;
  logic [WordW-1:0]  out_word_q;
  logic              keep_q, keep_d;
  logic              end_q;
  logic [FaultW-1:0] fault_q, fault_d;

  logic              adv;
  logic [CountW-1:0] count;
  logic [CountW-1:0] rem;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  assign count = s1_word_q[WordW-1 -: CountW];

  always_comb begin
    hdr_left_d   = hdr_left_q;
    words_left_d = words_left_q;
    dropping_d   = dropping_q;
    keep_d       = 1'b1;
    fault_d      = FaultNone;
    rem          = '0;
    if (hdr_left_q != '0) begin
      hdr_left_d = hdr_left_q - HdrW'(1);
    end else if (words_left_q == '0) begin
      // first word of an instruction: opcode low, word count high
      if (count == '0) begin
        fault_d = FaultZeroCount;
        rem     = '0;
      end else begin
        rem = count - CountW'(1);
      end
      dropping_d   = is_debug_op(s1_word_q[15:0]);
      keep_d       = !dropping_d;
      words_left_d = rem;
      if (s1_end_q && rem != '0) fault_d = FaultTruncated;
    end else begin
      keep_d       = !dropping_q;
      words_left_d = words_left_q - CountW'(1);
      if (s1_end_q && words_left_d != '0) fault_d = FaultTruncated;
    end
    if (s1_end_q) begin
      hdr_left_d   = HdrReset;
      words_left_d = '0;
      dropping_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hdr_left_q   <= HdrReset;
      words_left_q <= '0;
      dropping_q   <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (adv) begin
        out_valid_q  <= 1'b1;
        hdr_left_q   <= hdr_left_d;
        words_left_q <= words_left_d;
        dropping_q   <= dropping_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
      s1_end_q  <= module_end_i;
    end
    if (adv) begin
      out_word_q <= s1_word_q;
      keep_q     <= keep_d;
      end_q      <= s1_end_q;
      fault_q    <= fault_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;
  assign keep_o       = keep_q;
  assign stream_end_o = end_q;
  assign fault_o      = fault_q;

`ifndef SYNTHESIS
  // inside the header no instruction can be in flight
  a_hdr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_left_q != '0 |-> words_left_q == '0 && !dropping_q)
    else $error("instruction state live during header");

  // end of module puts the parser back to a fresh header
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_end_q |=> hdr_left_q == HdrReset && words_left_q == '0 && !dropping_q)
    else $error("parse state not reset after module end");

  // truncation is only reported on the last word of a module
  a_trunc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o == FaultTruncated |-> stream_end_o)
    else $error("truncation fault away from module end");

  // header words are always kept and never faulted
  a_hdr_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && hdr_left_q != '0 |=> keep_o && fault_o == FaultNone)
    else $error("header word dropped or faulted");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for spirv_debug_strip_filter_unit. Feeds whole and
// broken SPIR-V modules word by word, tracks the header/instruction parse in
// a scoreboard and compares every output transfer field by field, with random
// idle bursts on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import spdsf_pkg::*;

  localparam int unsigned NumWords   = 750;
  localparam int unsigned QuietAfter = 650;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned IdleLimit  = 1000;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic              keep;
    logic              stream_end;
    logic [FaultW-1:0] fault;
  } strip_result_t;

  // Parse tracker and queue of expected words
  class strip_scoreboard;
    logic [2:0]        hdr_left;
    logic [CountW-1:0] words_left;
    logic              dropping;
    strip_result_t     expected_q[$];
    int                failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      hdr_left   = 3'(HeaderWordsDefault);
      words_left = '0;
      dropping   = 1'b0;
    endfunction

    function logic debug_opcode(logic [15:0] op);
      case (op)
        OpNop, OpSourceContinued, OpSource, OpSourceExtension, OpName,
        OpMemberName, OpString, OpLine, OpNoLine, OpModuleProcessed: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void note_word(logic [WordW-1:0] w, logic eom);
      strip_result_t     r;
      logic [CountW-1:0] cnt;
      r.word       = w;
      r.stream_end = eom;
      r.fault      = FaultNone;
      if (hdr_left != 0) begin
        r.keep   = 1'b1;
        hdr_left = hdr_left - 3'd1;
      end else if (words_left == 0) begin
        cnt = w[31:16];
        if (cnt == 0) begin
          r.fault = FaultZeroCount;
          cnt     = 16'd1;
        end
        dropping   = debug_opcode(w[15:0]);
        r.keep     = !dropping;
        words_left = cnt - 16'd1;
        if (eom && words_left != 0) r.fault = FaultTruncated;
      end else begin
        r.keep     = !dropping;
        words_left = words_left - 16'd1;
        if (eom && words_left != 0) r.fault = FaultTruncated;
      end
      expected_q.push_back(r);
      if (eom) restart();
    endfunction

    function void check_result(strip_result_t got);
      strip_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("output transfer with nothing expected: word %h", got.word);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.word !== exp_r.word) begin
        $error("out_word: expected %h, got %h", exp_r.word, got.word);
        failures++;
      end
      if (got.keep !== exp_r.keep) begin
        $error("keep: expected %b, got %b (word %h)", exp_r.keep, got.keep, exp_r.word);
        failures++;
      end
      if (got.stream_end !== exp_r.stream_end) begin
        $error("stream_end: expected %b, got %b (word %h)", exp_r.stream_end,
               got.stream_end, exp_r.word);
        failures++;
      end
      if (got.fault !== exp_r.fault) begin
        $error("fault: expected %0d, got %0d (word %h)", exp_r.fault, got.fault,
               exp_r.word);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  in_word_i    = '0;
  logic              module_end_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [WordW-1:0]  out_word_o;
  logic              keep_o;
  logic              stream_end_o;
  logic [FaultW-1:0] fault_o;

  strip_scoreboard sb = new();
  bit              quiet     = 1'b0;
  bit              hold_req  = 1'b0;
  int unsigned     words_sent = 0;

  logic [15:0] debug_ops [10] = '{OpNop, OpSourceContinued, OpSource, OpSourceExtension,
                                  OpName, OpMemberName, OpString, OpLine, OpNoLine,
                                  OpModuleProcessed};

  spirv_debug_strip_filter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .module_end_i(module_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .keep_o      (keep_o),
    .stream_end_o(stream_end_o),
    .fault_o     (fault_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Input side: one transfer per call, optionally preceded by an idle burst
  task automatic send_word(input logic [WordW-1:0] w, input logic eom);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_word_i    <= w;
    module_end_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w, eom);
    words_sent++;
  endtask

  task automatic send_header(input int n, input logic end_last);
    for (int i = 0; i < n; i++) send_word($urandom, end_last && i == n - 1);
  endtask

  // First word carries count and opcode; n_sent may be short of cnt
  task automatic send_instr(input logic [15:0] op, input logic [15:0] cnt,
                            input int n_sent, input logic end_last);
    for (int i = 0; i < n_sent; i++)
      send_word((i == 0) ? {cnt, op} : $urandom, end_last && i == n_sent - 1);
  endtask

  function automatic logic [15:0] pick_opcode();
    if ($urandom_range(0, 1) == 0) return debug_ops[$urandom_range(0, 9)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_random_module();
    int          kind;
    int          n_instr;
    int unsigned cnt;
    int          n_sent;
    bit          last;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      n_sent = $urandom_range(1, 10);
      for (int i = 0; i < n_sent; i++) send_word($urandom, i == n_sent - 1);
    end else if (kind == 1) begin
      send_header($urandom_range(1, HeaderWordsDefault), 1'b1);
    end else begin
      send_header(HeaderWordsDefault, 1'b0);
      n_instr = $urandom_range(1, 12);
      for (int k = 0; k < n_instr; k++) begin
        last = (k == n_instr - 1);
        if ($urandom_range(0, 15) == 0) begin
          cnt    = 0;
          n_sent = 1;
        end else if (last && $urandom_range(0, 4) == 0) begin
          // cut short by the end of the module
          cnt    = $urandom_range(2, 65535);
          n_sent = $urandom_range(1, (cnt - 1 < 4) ? cnt - 1 : 4);
        end else begin
          cnt    = $urandom_range(1, 6);
          n_sent = cnt;
        end
        send_instr(pick_opcode(), 16'(cnt), n_sent, last);
      end
    end
  endtask

  // Output side: check each transfer, then choose ready for the next cycle
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result('{out_word_o, keep_o, stream_end_o, fault_o});
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: consecutive cycles with no transfer on either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Header with extreme words, every debug opcode, a kept instruction,
    // zero word count, then a truncated debug instruction ending the module
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0723_0203, 1'b0);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b0);
    foreach (debug_ops[i]) send_instr(debug_ops[i], 16'd1, 1, 1'b0);
    send_instr(16'hFFFF, 16'd2, 2, 1'b0);
    send_instr(16'd17, 16'd0, 1, 1'b0);
    send_instr(OpName, 16'hFFFF, 1, 1'b1);
    // Module ending inside its header
    send_header(2, 1'b1);

    hold_req = 1'b1;
    while (words_sent < NumWords) begin
      if (words_sent >= QuietAfter) quiet = 1'b1;
      send_random_module();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
